### rtl/core/tte_pkg.sv
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, constants and the integer-power table for the exp pipeline.
// ----------------------------------------------------------------------------
package tte_pkg;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_UFLOW = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;

    localparam int TAB_DEPTH = 64;
    localparam int TAB_IDX_W = 6;

    // 4/e in Q1.31
    localparam logic [31:0] INV_E_MANT = 32'd3160060337;

    // Taylor coefficients round(2^30/n!), Q2.30
    localparam logic [31:0] TTE_COEF [0:6] = '{
        32'd1073741824, 32'd1073741824, 32'd536870912, 32'd178956971,
        32'd44739243,   32'd8947849,    32'd1491308
    };

    typedef struct packed {
        logic [31:0]        mant;
        logic signed [7:0]  bexp;
    } t_tab_ent;

    typedef t_tab_ent [TAB_DEPTH-1:0] t_tab;

    // Item travelling down the Horner stages
    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        tmant;   // exp(-k) mantissa, Q1.31
        logic signed [7:0]  texp;    // exp(-k) binary exponent
        logic [29:0]        frac;    // fraction, Q0.30
        logic [31:0]        acc;     // Horner accumulator, Q2.30
    } t_tte_item;

    // exp(-k) by repeated multiplication with 4/e, evaluated at elaboration
    function automatic t_tab build_tab();
        t_tab        t;
        logic [31:0] m;
        logic [63:0] p;
        logic [32:0] r;
        int          ex;
        m  = 32'h8000_0000;
        ex = 0;
        for (int k = 0; k < TAB_DEPTH; k++) begin
            t[k].mant = m;
            t[k].bexp = 8'(ex);
            p = 64'(m) * 64'(INV_E_MANT);
            if (p[63]) begin
                r  = {1'b0, p[63:32]} + 33'(p[31]);
                ex = ex + 1;
            end else begin
                r  = {1'b0, p[62:31]} + 33'(p[30]);
            end
            if (r[32]) begin
                r  = 33'h0_8000_0000;
                ex = ex + 1;
            end
            ex = ex - 2;
            m  = r[31:0];
        end
        return t;
    endfunction

    localparam t_tab TTE_TAB = build_tab();

endpackage

### rtl/core/tte_decode.sv
// ----------------------------------------------------------------------------
// tte_decode
// Splits the argument into floor and fraction, flags range, reads exp(-k).
// ----------------------------------------------------------------------------
module tte_decode
    import tte_pkg::*;
#(
    parameter int TABLE_ENTRIES = 51,
    parameter int ARG_FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_vld,
    output logic        o_rdy,
    input  logic [31:0] i_x,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_tte_item   o_item
);

    localparam int IB = 32 - ARG_FRAC_BITS;

    logic            r_vld;
    t_tte_item       r_item;
    t_tte_item       n_item;
    logic [IB-1:0]   w_ip;
    logic [IB:0]     w_kx;
    logic [31:0]     w_k;
    logic            w_neg;

    assign w_neg = i_x[31];
    assign w_ip  = i_x[31:ARG_FRAC_BITS];
    // k = -floor(x) for negative x
    assign w_kx  = {1'b1, {IB{1'b0}}} - {1'b0, w_ip};
    assign w_k   = w_neg ? 32'(w_kx[IB-1:0]) : 32'd0;

    always_comb begin
        n_item.frac  = {i_x[ARG_FRAC_BITS-1:0], {(30-ARG_FRAC_BITS){1'b0}}};
        n_item.acc   = TTE_COEF[6];
        n_item.tmant = TTE_TAB[w_k[TAB_IDX_W-1:0]].mant;
        n_item.texp  = TTE_TAB[w_k[TAB_IDX_W-1:0]].bexp;
        if (!w_neg && (w_ip != '0)) begin
            n_item.status = ST_RANGE;
        end else if (w_k >= 32'(TABLE_ENTRIES)) begin
            n_item.status = ST_UFLOW;
        end else begin
            n_item.status = ST_OK;
        end
    end

    assign o_rdy = ~r_vld | i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

### rtl/core/tte_horner.sv
// ----------------------------------------------------------------------------
// tte_horner
// One Horner step: acc = c + round(acc * f / 2^30), registered.
// ----------------------------------------------------------------------------
module tte_horner
    import tte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic [31:0] i_coef,
    input  logic        i_vld,
    output logic        o_rdy,
    input  t_tte_item   i_item,
    output logic        o_vld,
    input  logic        i_rdy,
    output t_tte_item   o_item
);

    logic        r_vld;
    t_tte_item   r_item;
    t_tte_item   n_item;
    logic [61:0] w_prod;
    logic [61:0] w_rnd;

    assign w_prod = 62'(i_item.acc) * 62'(i_item.frac);
    assign w_rnd  = w_prod + 62'h2000_0000;

    always_comb begin
        n_item     = i_item;
        n_item.acc = i_coef + w_rnd[61:30];
    end

    assign o_rdy = ~r_vld | i_rdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_rdy) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;

endmodule

### rtl/core/tte_renorm.sv
// ----------------------------------------------------------------------------
// tte_renorm
// exp(-k) * exp(f) product, then renormalise to Q1.31 (output register).
// ----------------------------------------------------------------------------
module tte_renorm
    import tte_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_vld,
    output logic               o_rdy,
    input  t_tte_item          i_item,
    output logic               o_vld,
    input  logic               i_rdy,
    output logic [31:0]        o_mant,
    output logic signed [7:0]  o_bexp,
    output logic [1:0]         o_status
);

    // product stage
    logic               r_pvld;
    logic [63:0]        r_prod;
    logic signed [7:0]  r_pexp;
    logic [1:0]         r_pst;
    logic               w_prdy;

    // output stage
    logic               r_ovld;
    logic [31:0]        r_mant;
    logic signed [7:0]  r_bexp;
    logic [1:0]         r_st;
    logic [31:0]        n_mant;
    logic signed [7:0]  n_bexp;
    logic [32:0]        w_m;
    logic [7:0]         w_dexp;

    assign w_prdy = ~r_ovld | i_rdy;
    assign o_rdy  = ~r_pvld | w_prdy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pvld <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (o_rdy) begin
                r_pvld <= i_vld;
            end
            if (w_prdy) begin
                r_ovld <= r_pvld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rdy && i_vld) begin
            r_prod <= 64'(i_item.tmant) * 64'(i_item.acc);
            r_pexp <= i_item.texp;
            r_pst  <= i_item.status;
        end
    end

    // product lies in [2^61, 2^64): leading one at bit 61, 62 or 63
    always_comb begin
        if (r_prod[63]) begin
            w_m    = {1'b0, r_prod[63:32]} + 33'(r_prod[31]);
            w_dexp = 8'd2;
        end else if (r_prod[62]) begin
            w_m    = {1'b0, r_prod[62:31]} + 33'(r_prod[30]);
            w_dexp = 8'd1;
        end else begin
            w_m    = {1'b0, r_prod[61:30]} + 33'(r_prod[29]);
            w_dexp = 8'd0;
        end
        if (w_m[32]) begin
            n_mant = 32'h8000_0000;
            n_bexp = r_pexp + $signed(w_dexp) + 8'sd1;
        end else begin
            n_mant = w_m[31:0];
            n_bexp = r_pexp + $signed(w_dexp);
        end
        if (r_pst != ST_OK) begin
            n_mant = '0;
            n_bexp = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_prdy && r_pvld) begin
            r_mant <= n_mant;
            r_bexp <= n_bexp;
            r_st   <= r_pst;
        end
    end

    assign o_vld    = r_ovld;
    assign o_mant   = r_mant;
    assign o_bexp   = r_bexp;
    assign o_status = r_st;

endmodule

### rtl/core/table_taylor_exponential.sv
// ----------------------------------------------------------------------------
// table_taylor_exponential
// Fixed-point exp(x): table of exp(-k) times a degree-6 Taylor polynomial.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                                  | tuser
//  --------+-----+----------------------------------------+-------------------
//  s (in)  | in  | [31:0] x_value, signed fixed point     | -
//  m (out) | out | [31:0] mantissa Q1.31, [39:32] bin_exp | [1:0] status
//
//  One word in per cycle sustained while the result stream is not stalled;
//  one result word per argument. Stages: decode/table read, six Horner
//  multiply stages, the 32x32 product, then renormalisation into the output register.
//  Each stage holds its own valid bit; a stalled output only backs up
//  stages that are full, so bubbles close up and nothing is lost.
//  Reset (synchronous, active low) clears valid bits only.
// ----------------------------------------------------------------------------
module table_taylor_exponential
    import tte_pkg::*;
#(
    parameter int TABLE_ENTRIES = 51,
    parameter int ARG_FRAC_BITS = 24
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // argument stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [31:0] i_s_tdata,   // [31:0] x_value
    // result stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [39:0] o_m_tdata,   // [31:0] mantissa, [39:32] bin_exponent
    output logic [1:0]  o_m_tuser    // [1:0] status
);

    t_tte_item          w_item [0:6];
    logic               w_vld  [0:6];
    logic               w_rdy  [0:6];
    logic [31:0]        w_mant;
    logic signed [7:0]  w_bexp;

    // floor/fraction split; table of exp(-k) read here
    tte_decode #(
        .TABLE_ENTRIES (TABLE_ENTRIES),
        .ARG_FRAC_BITS (ARG_FRAC_BITS)
    ) u_decode (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_x     (i_s_tdata),
        .o_vld   (w_vld[0]),
        .i_rdy   (w_rdy[0]),
        .o_item  (w_item[0])
    );

    // Horner chain, highest coefficient first (c6 is the seed)
    for (genvar g = 0; g < 6; g++) begin : g_horner
        tte_horner u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_coef  (TTE_COEF[5-g]),
            .i_vld   (w_vld[g]),
            .o_rdy   (w_rdy[g]),
            .i_item  (w_item[g]),
            .o_vld   (w_vld[g+1]),
            .i_rdy   (w_rdy[g+1]),
            .o_item  (w_item[g+1])
        );
    end

    // final product and renormalisation, output register
    tte_renorm u_renorm (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_vld    (w_vld[6]),
        .o_rdy    (w_rdy[6]),
        .i_item   (w_item[6]),
        .o_vld    (o_m_tvalid),
        .i_rdy    (i_m_tready),
        .o_mant   (w_mant),
        .o_bexp   (w_bexp),
        .o_status (o_m_tuser)
    );

    assign o_m_tdata = {w_bexp, w_mant};

endmodule

### rtl/core/tte_check.sv
// ----------------------------------------------------------------------------
// tte_check
// Port-level checks on the argument and result streams, bound to the top level.
// ----------------------------------------------------------------------------
module tte_check
    import tte_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        o_s_tready,
    input logic [31:0] i_s_tdata,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [39:0] o_m_tdata,
    input logic [1:0]  o_m_tuser
);

    // a waiting argument word stays put until taken
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_tvalid && !o_s_tready |=> i_s_tvalid && $stable(i_s_tdata))
        else $error("argument word changed while waiting");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("result word changed while stalled");

    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tuser == ST_OK || o_m_tuser == ST_UFLOW
                        || o_m_tuser == ST_RANGE))
        else $error("undefined status code");

    // flushed results carry zero mantissa and exponent
    a_flush: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser != ST_OK) |-> (o_m_tdata == 40'd0))
        else $error("flagged result not zero");

    // valid results are normalised to [1,2)
    a_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && (o_m_tuser == ST_OK) |-> o_m_tdata[31])
        else $error("mantissa not normalised");

endmodule

bind table_taylor_exponential tte_check u_tte_check (.*);

### verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Streaming testbench for table_taylor_exponential.
//
// Arguments go in on the s channel and are predicted at the moment they are
// accepted; result words on the m channel are compared in order against the
// predictions, field by field. The predictor rebuilds exp(-k) by repeated
// multiplication with 4/e, runs the degree-6 Horner polynomial on the
// fraction and renormalises the product, all in plain integer arithmetic.
// Stimulus: a directed corner list, then random arguments, mostly inside the
// table's reach, with idle and back-pressure bursts that die away at the end.
// ----------------------------------------------------------------------------
module tb_top;

    // expected content of one result word
    typedef struct packed {
        logic [31:0]       mant;
        logic signed [7:0] bexp;
        logic [1:0]        status;
    } exp_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: predicts exp(x) per accepted argument, checks result words
    // ------------------------------------------------------------------------
    class exp_scoreboard;
        localparam int          N_POW  = 51;   // exp(-k) entries before underflow
        localparam int          FRAC_W = 24;   // argument fraction bits
        localparam logic [31:0] FOUR_OVER_E = 32'd3160060337;  // Q1.31

        logic [31:0]  pow_mant [64];
        int           pow_exp  [64];
        logic [31:0]  taylor_c [7];
        exp_result_t  pending_results [$];
        int           n_fail;

        function new();
            logic [31:0] m;
            int          e;
            n_fail = 0;
            // round(2^30 / n!), Q2.30
            taylor_c[0] = 32'd1073741824;
            taylor_c[1] = 32'd1073741824;
            taylor_c[2] = 32'd536870912;
            taylor_c[3] = 32'd178956971;
            taylor_c[4] = 32'd44739243;
            taylor_c[5] = 32'd8947849;
            taylor_c[6] = 32'd1491308;
            // exp(-k): one multiply by 4/e and a shift of two per step
            m = 32'h8000_0000;
            e = 0;
            for (int k = 0; k < 64; k++) begin
                pow_mant[k] = m;
                pow_exp[k]  = e;
                m = renorm(64'(m) * 64'(FOUR_OVER_E), 62, e);
                e -= 2;
            end
        endfunction

        // leading one to bit 31, round half up, carry into the exponent
        function logic [31:0] renorm(input logic [63:0] p, input int frac_bits,
                                     inout int ex);
            int          msb;
            int          sh;
            logic [63:0] m;
            msb = 63;
            while (msb > 32 && !p[msb])
                msb--;
            sh = msb - 31;
            m  = (p >> sh) + ((p >> (sh - 1)) & 64'd1);
            ex += msb - frac_bits;
            if (m >= 64'h1_0000_0000) begin
                m  = 64'h8000_0000;
                ex += 1;
            end
            return m[31:0];
        endfunction

        // 1 + f + f^2/2 + ... + f^6/720, f in Q0.30, result Q2.30
        function logic [31:0] taylor6(input logic [29:0] f);
            logic [63:0] acc;
            acc = 64'(taylor_c[6]);
            for (int n = 5; n >= 0; n--)
                acc = 64'(taylor_c[n]) + ((acc * 64'(f) + (64'd1 << 29)) >> 30);
            return acc[31:0];
        endfunction

        function exp_result_t exp_of_arg(input logic [31:0] x);
            exp_result_t            r;
            logic [31-FRAC_W:0]     ip;
            int                     k;
            int                     ex;
            logic [29:0]            f30;
            logic [31:0]            poly;
            r  = '0;
            ip = x[31:FRAC_W];
            // floor(x) >= 1
            if (!x[31] && ip != 0) begin
                r.status = tte_pkg::ST_RANGE;
                return r;
            end
            k = x[31] ? (1 << (32 - FRAC_W)) - int'(ip) : 0;
            // beyond the table: flushed to zero
            if (k >= N_POW) begin
                r.status = tte_pkg::ST_UFLOW;
                return r;
            end
            ex     = pow_exp[k];
            f30    = 30'(x[FRAC_W-1:0]) << (30 - FRAC_W);
            poly   = taylor6(f30);
            r.mant = renorm(64'(pow_mant[k]) * 64'(poly), 61, ex);
            r.bexp = 8'(ex);
            r.status = tte_pkg::ST_OK;
            return r;
        endfunction

        function void note_arg(input logic [31:0] x);
            pending_results.push_back(exp_of_arg(x));
        endfunction

        function void check_word(input logic [39:0] data, input logic [1:0] user);
            exp_result_t want;
            if (pending_results.size() == 0) begin
                $error("result word with nothing outstanding: tdata %h tuser %0d",
                       data, user);
                n_fail++;
                return;
            end
            want = pending_results.pop_front();
            if (data[31:0] !== want.mant) begin
                $error("mantissa: expected %h, actual %h", want.mant, data[31:0]);
                n_fail++;
            end
            if (data[39:32] !== want.bexp) begin
                $error("bin_exponent: expected %0d, actual %0d",
                       want.bexp, $signed(data[39:32]));
                n_fail++;
            end
            if (user !== want.status) begin
                $error("status: expected %0d, actual %0d", want.status, user);
                n_fail++;
            end
        endfunction

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT
    // ------------------------------------------------------------------------
    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [31:0] i_s_tdata;    // [31:0] x_value
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;    // [31:0] mantissa, [39:32] bin_exponent
    logic [1:0]  o_m_tuser;    // [1:0] status

    exp_scoreboard sb;

    // idle/stall control shared between the driver and the sink
    int gap_pct;
    int stall_pct;
    bit calm;
    int stall_left;

    localparam int N_RANDOM = 1530;
    localparam int N_CALM   = 200;    // tail with no idling at all

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    table_taylor_exponential i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // ------------------------------------------------------------------------
    // Monitor: both handshakes seen at the rising edge
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready)
                sb.note_arg(i_s_tdata);
            if (o_m_tvalid && i_m_tready)
                sb.check_word(o_m_tdata, o_m_tuser);
        end
    end

    // ------------------------------------------------------------------------
    // Result sink: tready drops in random bursts
    // ------------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
        end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
            i_m_tready <= 1'b0;
            stall_left <= $urandom_range(1, 7) - 1;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    // ------------------------------------------------------------------------
    // Argument driver
    // ------------------------------------------------------------------------
    // gap: idle cycles before the word; tvalid stays high back to back
    task automatic send_arg(input logic [31:0] x, input int gap);
        if (gap > 0) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= x;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    function automatic int pick_gap();
        if (!calm && $urandom_range(0, 99) < gap_pct)
            return $urandom_range(1, 7);
        return 0;
    endfunction

    function automatic int pick_pct();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 10;
            2:       return 35;
            default: return 70;
        endcase
    endfunction

    // mostly arguments the table covers; some at the edges; some anything
    function automatic logic [31:0] random_arg();
        int          sel;
        int          k;
        logic [31:0] base;
        sel = $urandom_range(0, 99);
        if (sel < 70) begin
            k = $urandom_range(0, 50);
            return {8'(256 - k), 24'($urandom)} & (k == 0 ? 32'h00FF_FFFF : '1);
        end else if (sel < 82) begin
            case ($urandom_range(0, 3))
                0:       base = 32'h0100_0000;    // 1.0
                1:       base = 32'h0000_0000;    // 0.0
                2:       base = 32'hCE00_0000;    // -50.0, last table entry
                default: base = 32'hCD00_0000;    // -51.0, first underflow
            endcase
            return base + 32'($urandom_range(0, 8)) - 32'd4;
        end
        return $urandom;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        logic [31:0] corner_args [$];
        int          n_idle;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_m_tready = 1'b0;
        stall_left = 0;
        calm       = 1'b0;
        gap_pct    = 25;
        stall_pct  = 25;
        sb = new();

        // rising edges with reset low, released at a falling edge
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed corners
        corner_args = '{
            32'h0000_0000,   // zero
            32'h0000_0001,   // smallest positive
            32'h0080_0000,   // 0.5
            32'h00FF_FFFF,   // just below one
            32'h0100_0000,   // exactly one: out of range
            32'h4000_0000,   // large positive
            32'h7FFF_FFFF,   // largest argument
            32'hFFFF_FFFF,   // smallest negative, floor -1
            32'hFF00_0000,   // -1
            32'hFF80_0000,   // -0.5
            32'hFE00_0000,   // -2
            32'hF0AA_5555,   // -16 plus a fraction
            32'hE000_0000,   // -32
            32'hCE00_0000,   // -50, last table entry
            32'hCE00_0001,
            32'hCEFF_FFFF,
            32'hCDFF_FFFF,   // floor -51: underflow
            32'hCD00_0000,   // -51
            32'hC000_0000,   // -64
            32'h8000_0001,
            32'h8000_0000    // most negative
        };
        foreach (corner_args[i])
            send_arg(corner_args[i], pick_gap());

        // random words; idling profile changes every hundred
        for (int i = 0; i < N_RANDOM; i++) begin
            if (i % 100 == 0) begin
                gap_pct   = pick_pct();
                stall_pct = pick_pct();
            end
            if (i == N_RANDOM - N_CALM)
                calm = 1'b1;
            send_arg(random_arg(), pick_gap());
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;

        // drain, then allow for the pipeline depth
        while (sb.pending() != 0)
            @(posedge i_clk);
        n_idle = 12;
        repeat (n_idle) @(posedge i_clk);

        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // watchdog
    initial begin
        #6000000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### table_taylor_exponential.f
rtl/core/tte_pkg.sv
rtl/core/tte_decode.sv
rtl/core/tte_horner.sv
rtl/core/tte_renorm.sv
rtl/core/table_taylor_exponential.sv
rtl/core/tte_check.sv
verif/tb_top.sv
